// ----- rtl/dmwt_pkg.sv -----
package dmwt_pkg;

	// field widths of one request and one response
	localparam int KEY_W  = 16;
	localparam int DATA_W = 32;
	localparam int MODE_W = 2;

	// default geometry
	localparam int CACHE_LINES_DEF   = 128;
	localparam int STORE_ENTRIES_DEF = 1024;

	// request opcodes; the fourth code is a no-op
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd2;

	// one cache line as held in the line RAM
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] value;
	} line_t;

endpackage

// ----- rtl/direct_mapped_write_through_cache.sv -----
// Channel   Dir  tdata (low bit up)             tuser (low bit up)
// s_axis    in   key[15:0], write_value[47:16]  mode[1:0]
// m_axis    out  read_data[31:0]                hit[0], status[1]
//
// Each request passes through accept (slot quotient by reciprocal multiply,
// store read), lookup (line RAM read) and respond (compare, write back, result).
// After reset the store is loaded with its own index, one entry a cycle, with
// s_axis_tready low until all STORE_ENTRIES (1024 by default) are written.
// A result waits in the output register; the next request is accepted meanwhile,
// and the respond cycle holds while that register is still full.
module direct_mapped_write_through_cache #(
	parameter int CACHE_LINES   = dmwt_pkg::CACHE_LINES_DEF,
	parameter int STORE_ENTRIES = dmwt_pkg::STORE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // key, write_value
	input  logic [1:0]  s_axis_tuser,   // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // read_data
	output logic [1:0]  m_axis_tuser    // hit, status
);
	import dmwt_pkg::*;

	localparam int SW = $clog2(CACHE_LINES);
	localparam int AW = $clog2(STORE_ENTRIES);

	typedef enum logic [3:0] {
		ST_INIT = 4'b0001,
		ST_IDLE = 4'b0010,
		ST_LOOK = 4'b0100,
		ST_RESP = 4'b1000
	} state_t;

	state_t state_q;
	logic [AW-1:0] init_cnt_q;
	logic          init_last;

	logic              in_accept;
	logic              out_free;
	logic              fire_resp;

	logic [MODE_W-1:0] mode_q;
	logic [KEY_W-1:0]  key_q;
	logic [DATA_W-1:0] wv_q;
	logic [SW-1:0]     slot;
	logic [SW-1:0]     slot_q;
	logic [CACHE_LINES-1:0] valid_q;

	logic              in_range;
	logic              hit_c;
	logic [DATA_W-1:0] data_c;
	logic              status_c;
	logic              fill_c;
	logic [DATA_W-1:0] fill_val_c;
	logic              st_we_c;
	logic              flush_c;

	logic              st_we;
	logic [AW-1:0]     st_waddr;
	logic [DATA_W-1:0] st_wdata;
	logic [DATA_W-1:0] st_rdata;
	line_t             line_wdata;
	line_t             line_rdata;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign fire_resp     = (state_q == ST_RESP) && out_free;
	assign init_last     = (init_cnt_q == AW'(STORE_ENTRIES - 1));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			init_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					init_cnt_q <= init_cnt_q + AW'(1);
					if (init_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: state_q <= ST_RESP;
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_INIT;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (in_accept) begin
			mode_q <= s_axis_tuser;
			key_q  <= s_axis_tdata[KEY_W-1:0];
			wv_q   <= s_axis_tdata[KEY_W+DATA_W-1:KEY_W];
		end
		if (state_q == ST_LOOK) begin
			slot_q <= slot;
		end
	end

	// line index = key mod CACHE_LINES
	dmwt_slot #(
		.CACHE_LINES(CACHE_LINES),
		.SW         (SW)
	) u_slot (
		.clk   (clk),
		.load  (in_accept),
		.key_in(s_axis_tdata[KEY_W-1:0]),
		.slot  (slot)
	);

	assign in_range = ({1'b0, key_q} < (KEY_W+1)'(STORE_ENTRIES));

	// response and write-back decision
	always_comb begin
		hit_c      = 1'b0;
		data_c     = '0;
		status_c   = 1'b0;
		fill_c     = 1'b0;
		fill_val_c = st_rdata;
		st_we_c    = 1'b0;
		flush_c    = 1'b0;
		unique case (mode_q)
			MODE_READ: begin
				if (valid_q[slot_q] && (line_rdata.key == key_q)) begin
					hit_c  = 1'b1;
					data_c = line_rdata.value;
				end else if (in_range) begin
					data_c = st_rdata;
					fill_c = 1'b1;
				end else begin
					status_c = 1'b1;
				end
			end
			MODE_WRITE: begin
				if (in_range) begin
					st_we_c    = 1'b1;
					fill_c     = 1'b1;
					fill_val_c = wv_q;
				end else begin
					status_c = 1'b1;
				end
			end
			MODE_FLUSH: flush_c = 1'b1;
			default: ;
		endcase
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (fire_resp) begin
			if (flush_c) begin
				valid_q <= '0;
			end else if (fill_c) begin
				valid_q[slot_q] <= 1'b1;
			end
		end
	end

	// backing store: index load after reset, then write-through
	assign st_we    = (state_q == ST_INIT) || (fire_resp && st_we_c);
	assign st_waddr = (state_q == ST_INIT) ? init_cnt_q : key_q[AW-1:0];
	assign st_wdata = (state_q == ST_INIT) ? DATA_W'(init_cnt_q) : wv_q;

	dmwt_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STORE_ENTRIES),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.re   (in_accept),
		.raddr(s_axis_tdata[AW-1:0]),
		.rdata(st_rdata)
	);

	// line RAM: key and value per line
	assign line_wdata.key   = key_q;
	assign line_wdata.value = fill_val_c;

	dmwt_ram #(
		.WIDTH($bits(line_t)),
		.DEPTH(CACHE_LINES),
		.AW   (SW)
	) u_lines (
		.clk  (clk),
		.we   (fire_resp && fill_c),
		.waddr(slot_q),
		.wdata(line_wdata),
		.re   (state_q == ST_LOOK),
		.raddr(slot),
		.rdata(line_rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (fire_resp) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_resp) begin
			m_axis_tdata <= data_c;
			m_axis_tuser <= {status_c, hit_c};
		end
	end

endmodule

// ----- rtl/dmwt_ram.sv -----
module dmwt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, held until the next read enable
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/dmwt_slot.sv -----
module dmwt_slot #(
	parameter int CACHE_LINES = 128,
	parameter int SW          = $clog2(CACHE_LINES)
) (
	input  logic                       clk,
	input  logic                       load,
	input  logic [dmwt_pkg::KEY_W-1:0] key_in,
	output logic [SW-1:0]              slot
);
	import dmwt_pkg::*;

	// key / CACHE_LINES by reciprocal; exact for 16-bit keys with a 32-bit shift
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / CACHE_LINES + 1);

	logic [KEY_W+31:0] prod;
	logic [KEY_W-1:0]  quot;
	logic [SW-1:0]     key_s1;
	logic [SW-1:0]     quot_s1;

	assign prod = (KEY_W+32)'(key_in) * (KEY_W+32)'(RECIP);
	assign quot = prod[KEY_W+31:32];

	// quotient registered before the back multiply
	always_ff @(posedge clk) begin
		if (load) begin
			key_s1  <= key_in[SW-1:0];
			quot_s1 <= quot[SW-1:0];
		end
	end

	// remainder is below CACHE_LINES, so only the low bits are needed
	assign slot = key_s1 - quot_s1 * SW'(CACHE_LINES);

endmodule

// ----- tb/cache_response_checker.sv -----
// Watches both channels of the cache, predicts every response from its own
// copy of the line RAM and the backing store, and compares in order.
module cache_response_checker #(
	parameter int CACHE_LINES   = dmwt_pkg::CACHE_LINES_DEF,
	parameter int STORE_ENTRIES = dmwt_pkg::STORE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // key, write_value
	input  logic [1:0]  s_axis_tuser,   // mode
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,   // read_data
	input  logic [1:0]  m_axis_tuser,   // hit, status
	output int          fail_cnt,
	output int          pending,
	output int          resp_cnt,
	output int          hit_cnt,
	output int          range_err_cnt
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                      hit;
		logic [dmwt_pkg::DATA_W-1:0] data;
		logic                      status;
	} cache_resp_t;

	// shadow of the cache and its backing store
	logic [dmwt_pkg::KEY_W-1:0]  shadow_key   [CACHE_LINES];
	logic [dmwt_pkg::DATA_W-1:0] shadow_value [CACHE_LINES];
	bit                          shadow_valid [CACHE_LINES];
	logic [dmwt_pkg::DATA_W-1:0] shadow_store [STORE_ENTRIES];

	cache_resp_t expected_resp_q[$];

	// one access against the shadow state; returns the response it gives
	function automatic cache_resp_t predict_access(logic [1:0] mode, logic [15:0] key,
		logic [31:0] wval);
		cache_resp_t r;
		int          slot;
		bit          in_range;
		r        = '0;
		slot     = int'(key) % CACHE_LINES;
		in_range = int'(key) < STORE_ENTRIES;
		case (mode)
			dmwt_pkg::MODE_READ: begin
				if (shadow_valid[slot] && shadow_key[slot] == key) begin
					r.hit  = 1'b1;
					r.data = shadow_value[slot];
				end else if (in_range) begin
					r.data             = shadow_store[key];
					shadow_key[slot]   = key;
					shadow_value[slot] = r.data;
					shadow_valid[slot] = 1'b1;
				end else begin
					r.status = 1'b1;
				end
			end
			dmwt_pkg::MODE_WRITE: begin
				if (in_range) begin
					shadow_store[key]  = wval;
					shadow_key[slot]   = key;
					shadow_value[slot] = wval;
					shadow_valid[slot] = 1'b1;
				end else begin
					r.status = 1'b1;
				end
			end
			dmwt_pkg::MODE_FLUSH: begin
				for (int i = 0; i < CACHE_LINES; i++)
					shadow_valid[i] = 1'b0;
			end
			default: ;  // spare code changes nothing
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("[%0t] response %0d: %s got 0x%0h, expected 0x%0h",
			$time, resp_cnt, what, got, want);
		fail_cnt++;
	endtask

	// sample both channels at each edge; response side first so a result
	// never pairs with a request accepted on the same edge
	always @(posedge clk or negedge arst_n) begin : monitor
		cache_resp_t want;
		if (!arst_n) begin
			for (int i = 0; i < CACHE_LINES; i++) begin
				shadow_valid[i] = 1'b0;
				shadow_key[i]   = '0;
				shadow_value[i] = '0;
			end
			for (int i = 0; i < STORE_ENTRIES; i++)
				shadow_store[i] = i;
			expected_resp_q.delete();
			fail_cnt      = 0;
			pending       = 0;
			resp_cnt      = 0;
			hit_cnt       = 0;
			range_err_cnt = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_resp_q.size() == 0) begin
					report_mismatch("unrequested transaction, read_data", m_axis_tdata, '0);
				end else begin
					want = expected_resp_q.pop_front();
					if (m_axis_tuser[0] !== want.hit)
						report_mismatch("hit", 32'(m_axis_tuser[0]), 32'(want.hit));
					if (m_axis_tdata !== want.data)
						report_mismatch("read_data", m_axis_tdata, want.data);
					if (m_axis_tuser[1] !== want.status)
						report_mismatch("status", 32'(m_axis_tuser[1]), 32'(want.status));
					hit_cnt       += want.hit;
					range_err_cnt += want.status;
				end
				resp_cnt++;
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_resp_q.push_back(predict_access(s_axis_tuser, s_axis_tdata[15:0],
					s_axis_tdata[47:16]));
			pending = expected_resp_q.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          CACHE_LINES   = dmwt_pkg::CACHE_LINES_DEF;
	localparam int          STORE_ENTRIES = dmwt_pkg::STORE_ENTRIES_DEF;
	localparam logic [1:0]  MODE_NOP      = 2'd3;
	localparam int          STUCK_LIMIT   = 20000;
	localparam int          PHASE_ITEMS   = 350;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;   // key, write_value
	logic [1:0]  s_axis_tuser;   // mode
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;   // read_data
	logic [1:0]  m_axis_tuser;   // hit, status

	int fail_cnt, pending, resp_cnt, hit_cnt, range_err_cnt;
	int send_idle_pct, recv_stall_pct;
	int n_read, n_write, n_flush, n_nop;
	int stuck_cycles;

	direct_mapped_write_through_cache #(
		.CACHE_LINES  (CACHE_LINES),
		.STORE_ENTRIES(STORE_ENTRIES)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	cache_response_checker #(
		.CACHE_LINES  (CACHE_LINES),
		.STORE_ENTRIES(STORE_ENTRIES)
	) resp_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.fail_cnt     (fail_cnt),
		.pending      (pending),
		.resp_cnt     (resp_cnt),
		.hit_cnt      (hit_cnt),
		.range_err_cnt(range_err_cnt)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// response side back-pressure
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

	// watchdog: cycles with no transaction on either channel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stuck_cycles <= 0;
		end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles, %0d responses pending",
					stuck_cycles, pending);
				$display("[direct_mapped_write_through_cache] ERROR");
				$finish;
			end
		end
	end

	// one request; tready is looked at on the falling edge, where it is settled
	// for the rising edge that follows
	task automatic send_req(logic [1:0] mode, logic [15:0] key, logic [31:0] wval);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {wval, key};
		s_axis_tuser  <= mode;
		@(negedge clk);
		while (!s_axis_tready)
			@(negedge clk);
		@(posedge clk);
		case (mode)
			dmwt_pkg::MODE_READ:  n_read++;
			dmwt_pkg::MODE_WRITE: n_write++;
			dmwt_pkg::MODE_FLUSH: n_flush++;
			default:              n_nop++;
		endcase
	endtask

	// hold requests until every response is back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// mostly a small hot set of keys that share slots, some spread, some out of range
	function automatic logic [15:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 16'($urandom_range(STORE_ENTRIES, 65535));
		else if (r < 60)
			return 16'($urandom_range(0, 15) + CACHE_LINES * $urandom_range(0, 3));
		else
			return 16'($urandom_range(0, STORE_ENTRIES - 1));
	endfunction

	function automatic logic [1:0] pick_mode();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)      return dmwt_pkg::MODE_READ;
		else if (r < 85) return dmwt_pkg::MODE_WRITE;
		else if (r < 88) return dmwt_pkg::MODE_FLUSH;
		else if (r < 90) return MODE_NOP;
		else             return dmwt_pkg::MODE_READ;
	endfunction

	initial begin
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tuser   = dmwt_pkg::MODE_READ;
		arst_n         = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		n_read  = 0;
		n_write = 0;
		n_flush = 0;
		n_nop   = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: misses, hits, eviction, range errors, spare code, flush
		send_req(dmwt_pkg::MODE_READ,  16'd0,     32'h0);          // cold miss
		send_req(dmwt_pkg::MODE_READ,  16'd0,     32'h0);          // hit
		send_req(dmwt_pkg::MODE_READ,  16'd1023,  32'h0);          // top of store
		send_req(dmwt_pkg::MODE_WRITE, 16'd1023,  32'h8000_0000);
		send_req(dmwt_pkg::MODE_READ,  16'd1023,  32'h0);          // hit on written line
		send_req(dmwt_pkg::MODE_WRITE, 16'd5,     32'h7FFF_FFFF);
		send_req(dmwt_pkg::MODE_READ,  16'd133,   32'h0);          // evicts key 5
		send_req(dmwt_pkg::MODE_READ,  16'd5,     32'h0);          // refill from store
		send_req(dmwt_pkg::MODE_READ,  16'd1024,  32'h0);          // first key out of range
		send_req(dmwt_pkg::MODE_READ,  16'hFFFF,  32'h0);
		send_req(dmwt_pkg::MODE_WRITE, 16'd1024,  32'hFFFF_FFFF);
		send_req(dmwt_pkg::MODE_WRITE, 16'hFFFF,  32'h1234_5678);
		send_req(dmwt_pkg::MODE_READ,  16'hFFFF,  32'h0);
		send_req(MODE_NOP,             16'hFFFF,  32'hFFFF_FFFF);
		send_req(MODE_NOP,             16'd0,     32'h0);
		send_req(dmwt_pkg::MODE_READ,  16'd0,     32'h0);          // still a hit
		send_req(dmwt_pkg::MODE_FLUSH, 16'hAAAA,  32'h5555_5555);
		send_req(dmwt_pkg::MODE_READ,  16'd0,     32'h0);          // miss after flush
		send_req(dmwt_pkg::MODE_READ,  16'd1023,  32'h0);          // store kept the write
		send_req(dmwt_pkg::MODE_WRITE, 16'd0,     32'h0);
		send_req(dmwt_pkg::MODE_WRITE, 16'd0,     32'hFFFF_FFFF);
		send_req(dmwt_pkg::MODE_READ,  16'd0,     32'h0);
		send_req(dmwt_pkg::MODE_FLUSH, 16'h5555,  32'hAAAA_AAAA);
		send_req(dmwt_pkg::MODE_FLUSH, 16'd0,     32'h0);          // flush of empty cache
		send_req(dmwt_pkg::MODE_READ,  16'd640,   32'h0);
		drain();

		// random phases: free flow, idle sender, stalling receiver, both lightly
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
				default: begin send_idle_pct = 12; recv_stall_pct = 12; end
			endcase
			repeat (PHASE_ITEMS)
				send_req(pick_mode(), pick_key(), $urandom());
			drain();
		end
		recv_stall_pct = 0;
		repeat (16) @(posedge clk);

		$display("requests: %0d reads, %0d writes, %0d flushes, %0d spare-code",
			n_read, n_write, n_flush, n_nop);
		$display("responses checked: %0d, read hits %0d, out-of-range %0d",
			resp_cnt, hit_cnt, range_err_cnt);
		if (fail_cnt == 0 && pending == 0)
			$display("[direct_mapped_write_through_cache] OK");
		else
			$display("[direct_mapped_write_through_cache] ERROR");
		$finish;
	end

endmodule
